>>> rtl/keypad_code_lock_controller_top_defines.svh
// Assertion macros for the keypad code lock controller checker.
// Depends on nothing; included by kclc_checker.sv.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define KCLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kclc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KCLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kclc assertion failed");

`endif

>>> rtl/kclc_pkg.sv
// Shared types and constants of the keypad code lock controller.
// No dependencies; imported by every RTL file of the block except kclc_ifs.sv.
package kclc_pkg;

  // Default number of code digits
  localparam int unsigned CODE_DIGITS = 4;

  localparam int unsigned TimerW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam logic [TimerW-1:0] TIMER_MAX = {TimerW{1'b1}};
  localparam logic [3:0] WRONG_MAX = 4'hF;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_9    = 8'h39;

  // Register reset values
  localparam logic [31:0] CODE_RST    = 32'h3132_3334;
  localparam logic [3:0]  LIMIT_RST   = 4'd3;
  localparam logic [23:0] OPEN_RST    = 24'd5000;
  localparam logic [23:0] LOCKOUT_RST = 24'd15000;
  localparam logic [23:0] NOTICE_RST  = 24'd2000;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_KEY      = 2'd1,
    REQ_PRESENCE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ENTRY   = 3'd1,
    MODE_NOTICE  = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_LOCKOUT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GRANTED  = 3'd1,
    EV_WRONG    = 3'd2,
    EV_LOCKOUT  = 3'd3,
    EV_ENTRY    = 3'd4,
    EV_LOCK_END = 3'd5,
    EV_RELOCKED = 3'd6
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CODE_VALUE    = 3'd0,
    CFG_ATTEMPT_LIMIT = 3'd1,
    CFG_OPEN_TICKS    = 3'd2,
    CFG_LOCKOUT_TICKS = 3'd3,
    CFG_NOTICE_TICKS  = 3'd4
  } cfg_idx_e;

  // Configuration seen by the core
  typedef struct packed {
    logic [31:0]       code_value;
    logic [3:0]        attempt_limit;
    logic [TimerW-1:0] open_ticks;
    logic [TimerW-1:0] lockout_ticks;
    logic [TimerW-1:0] notice_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [2:0] mode;
    logic       lock_open;
    logic       alarm_on;
    logic [3:0] tries_left;
    logic [2:0] digits_held;
    logic [2:0] event_code;
  } res_t;

endpackage

>>> rtl/kclc_ifs.sv
// Handshake channel interfaces of the keypad code lock controller.
// Depends on nothing; used by the top level, the configuration registers and the output register.
interface kclc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] key_code;

  modport source (output valid, req_type, key_code, input ready);
  modport sink   (input valid, req_type, key_code, output ready);
endinterface

interface kclc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       lock_open;
  logic       alarm_on;
  logic [3:0] tries_left;
  logic [2:0] digits_held;
  logic [2:0] event_code;

  modport source (output valid, mode, lock_open, alarm_on, tries_left, digits_held,
                  event_code, input ready);
  modport sink   (input valid, mode, lock_open, alarm_on, tries_left, digits_held,
                  event_code, output ready);
endinterface

interface kclc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/keypad_code_lock_controller_top.sv
// Channel  | Dir | Payload                                         | Accepted when
// cfg_i    | in  | index, data                                     | valid (ready tied high)
// in_i     | in  | req_type, key_code                              | valid && ready
// out_o    | out | mode, lock_open, alarm_on, tries_left,          | valid && ready
//          |     | digits_held, event_code                         |
// One item per cycle while in_i.ready is high: the lock state updates at the accepting
// edge and the output register loads the result at that same edge. in_i.ready drops
// only while a result waits and out_o.ready is low. Reset is immediate; no clearing pass.
// Top level of the keypad code lock controller; depends on kclc_pkg, kclc_ifs,
// kclc_cfg_regs, kclc_core and kclc_out_reg.
module keypad_code_lock_controller_top
  import kclc_pkg::*;
#(
  parameter int unsigned CodeDigits = CODE_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kclc_cfg_if.sink   cfg_i,
  kclc_in_if.sink    in_i,
  kclc_out_if.source out_o
);

  cfg_t cfg;
  res_t res;
  logic can_load;
  logic accept;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  kclc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  kclc_core #(
    .CodeDigits (CodeDigits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (in_i.req_type),
    .key_code_i (in_i.key_code),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  kclc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

>>> rtl/kclc_cfg_regs.sv
// Configuration register file of the keypad code lock controller.
// Depends on kclc_pkg and kclc_cfg_if.
module kclc_cfg_regs
  import kclc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  kclc_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_CODE_VALUE:    cfg_d.code_value    = cfg_i.data;
        CFG_ATTEMPT_LIMIT: cfg_d.attempt_limit = cfg_i.data[3:0];
        CFG_OPEN_TICKS:    cfg_d.open_ticks    = cfg_i.data[TimerW-1:0];
        CFG_LOCKOUT_TICKS: cfg_d.lockout_ticks = cfg_i.data[TimerW-1:0];
        CFG_NOTICE_TICKS:  cfg_d.notice_ticks  = cfg_i.data[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_value    <= CODE_RST;
      cfg_q.attempt_limit <= LIMIT_RST;
      cfg_q.open_ticks    <= OPEN_RST;
      cfg_q.lockout_ticks <= LOCKOUT_RST;
      cfg_q.notice_ticks  <= NOTICE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/kclc_core.sv
// Lock state and per-item update logic of the keypad code lock controller.
// Depends on kclc_pkg.
module kclc_core
  import kclc_pkg::*;
#(
  parameter int unsigned CodeDigits = CODE_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] key_code_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam int unsigned CntW = $clog2(CodeDigits + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CodeDigits);

  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [3:0]        wrong_q, wrong_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [7:0]        digits_q [CodeDigits];

  logic [TimerW-1:0] timer_inc;
  logic [TimerW-1:0] phase_len;
  logic [3:0]        wrong_inc;
  logic              digit_we;
  logic              is_digit;
  logic              code_match;
  logic [CodeDigits-1:0] digit_eq;
  logic [63:0]       code_ext;
  event_e            ev;
  logic [CntW+2:0]   count_ext;

  assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + TimerW'(1);
  assign wrong_inc = (wrong_q == WRONG_MAX) ? wrong_q : wrong_q + 4'd1;
  assign is_digit  = (key_code_i >= KEY_0) && (key_code_i <= KEY_9);

  // Compare each stored digit with its byte of the code; bits above 31 read zero
  assign code_ext = {32'd0, cfg_i.code_value};
  for (genvar i = 0; i < CodeDigits; i++) begin : g_cmp
    assign digit_eq[i] = (digits_q[i] == code_ext[8*(CodeDigits-1-i) +: 8]);
  end
  assign code_match = &digit_eq;

  // Length of the current timed phase
  always_comb begin
    case (mode_q)
      MODE_NOTICE:  phase_len = cfg_i.notice_ticks;
      MODE_OPEN:    phase_len = cfg_i.open_ticks;
      MODE_LOCKOUT: phase_len = cfg_i.lockout_ticks;
      default:      phase_len = TIMER_MAX;
    endcase
  end

  // Next state for one item
  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    wrong_d  = wrong_q;
    timer_d  = timer_q;
    digit_we = 1'b0;
    ev       = EV_NONE;
    unique case (req_type_i)
      REQ_TICK: begin
        case (mode_q) inside
          MODE_NOTICE, MODE_OPEN, MODE_LOCKOUT: begin
            if (timer_inc < phase_len) begin
              timer_d = timer_inc;
            end else begin
              timer_d = '0;
              if (mode_q == MODE_NOTICE) begin
                mode_d = MODE_ENTRY;
              end else if (mode_q == MODE_OPEN) begin
                mode_d = MODE_IDLE;
                ev     = EV_RELOCKED;
              end else begin
                mode_d  = MODE_IDLE;
                wrong_d = '0;
                ev      = EV_LOCK_END;
              end
            end
          end
          default: ;
        endcase
      end
      REQ_KEY: begin
        if (mode_q == MODE_ENTRY) begin
          if (key_code_i == KEY_HASH) begin
            if (count_q == CntFull) begin
              timer_d = '0;
              if (code_match) begin
                wrong_d = '0;
                mode_d  = MODE_OPEN;
                ev      = EV_GRANTED;
              end else if (wrong_inc >= cfg_i.attempt_limit) begin
                wrong_d = wrong_inc;
                mode_d  = MODE_LOCKOUT;
                ev      = EV_LOCKOUT;
              end else begin
                wrong_d = wrong_inc;
                count_d = '0;
                mode_d  = MODE_NOTICE;
                ev      = EV_WRONG;
              end
            end
          end else if (key_code_i == KEY_STAR) begin
            count_d = '0;
          end else if (is_digit && (count_q < CntFull)) begin
            digit_we = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
      end
      REQ_PRESENCE: begin
        if (mode_q == MODE_IDLE) begin
          count_d = '0;
          mode_d  = MODE_ENTRY;
          ev      = EV_ENTRY;
        end
      end
      default: ;
    endcase
  end

  // Hold control state; advance only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      wrong_q <= '0;
      timer_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      wrong_q <= wrong_d;
      timer_q <= timer_d;
    end
  end

  // Digit buffer; only slots below the fill count are ever compared
  for (genvar i = 0; i < CodeDigits; i++) begin : g_buf
    always_ff @(posedge clk_i) begin
      if (accept_i && digit_we && (count_q == CntW'(i))) begin
        digits_q[i] <= key_code_i;
      end
    end
  end

  // Result of this item, taken after the update
  assign count_ext = {3'd0, count_d};
  always_comb begin
    res_o.mode        = mode_d;
    res_o.lock_open   = (mode_d == MODE_OPEN);
    res_o.alarm_on    = (mode_d == MODE_LOCKOUT);
    res_o.tries_left  = (cfg_i.attempt_limit > wrong_d) ? cfg_i.attempt_limit - wrong_d
                                                         : 4'd0;
    res_o.digits_held = count_ext[2:0];
    res_o.event_code  = ev;
  end

endmodule

>>> rtl/kclc_out_reg.sv
// Result register of the keypad code lock controller.
// Depends on kclc_pkg and kclc_out_if.
module kclc_out_reg
  import kclc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_t      res_i,
  output logic      can_load_o,
  kclc_out_if.source out_o
);

  logic valid_q;
  res_t res_q;

  // Room for a new item when empty or when the held one leaves this cycle
  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.mode        = res_q.mode;
  assign out_o.lock_open   = res_q.lock_open;
  assign out_o.alarm_on    = res_q.alarm_on;
  assign out_o.tries_left  = res_q.tries_left;
  assign out_o.digits_held = res_q.digits_held;
  assign out_o.event_code  = res_q.event_code;

endmodule

>>> rtl/kclc_checker.sv
// Port-level checks of the keypad code lock controller, bound to the top level.
// Depends on kclc_pkg and keypad_code_lock_controller_top_defines.svh.
`include "keypad_code_lock_controller_top_defines.svh"

module kclc_checker
  import kclc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] mode,
  input logic       lock_open,
  input logic       alarm_on,
  input logic [2:0] digits_held,
  input logic [2:0] event_code
);

  logic       entry_seen;
  logic       entry_clean;
  logic       stalled;
  logic [5:0] shown;

  // Conditions used by the checks below
  assign entry_seen  = out_valid && (event_code == EV_ENTRY);
  assign entry_clean = (mode == MODE_ENTRY) && (digits_held == 3'd0);
  assign stalled     = out_valid && !out_ready;
  assign shown       = {mode, event_code};

  // Lock drive follows the open mode
  `KCLC_ASSERT_SAME(a_open_mode, clk_i, rst_ni, out_valid, lock_open == (mode == MODE_OPEN))

  // Alarm follows the lockout mode
  `KCLC_ASSERT_SAME(a_alarm_mode, clk_i, rst_ni, out_valid, alarm_on == (mode == MODE_LOCKOUT))

  // A new entry starts in entry mode with an empty buffer
  `KCLC_ASSERT_SAME(a_entry_start, clk_i, rst_ni, entry_seen, entry_clean)

  // A stalled result holds
  `KCLC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stalled, out_valid && $stable(shown))

endmodule

bind keypad_code_lock_controller_top kclc_checker u_kclc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .mode        (out_o.mode),
  .lock_open   (out_o.lock_open),
  .alarm_on    (out_o.alarm_on),
  .digits_held (out_o.digits_held),
  .event_code  (out_o.event_code)
);
